[rtl/core/fnv_keyed_chained_hash_table_macros.svh]
// Assertion macros used by the checker file of the keyed hash table.
// No dependencies; include by bare file name.
`ifndef FNV_KEYED_CHAINED_HASH_TABLE_MACROS_SVH
`define FNV_KEYED_CHAINED_HASH_TABLE_MACROS_SVH

// Concurrent assertion, quiet while reset is high.
`define FNVKHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that also holds across reset.
`define FNVKHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/fnvkht_pkg.sv]
// Package for the keyed FNV-1a chained hash table: sizes, codes, beat types,
// controller/datapath command and status structs, hash step function. No dependencies.
package fnvkht_pkg;

  localparam int NODE_COUNT   = 64;
  localparam int BUCKET_COUNT = 16;

  // 64-bit FNV prime is 2^40 + FNV_PRIME_LO
  localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam int          FNV_PRIME_SH = 40;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_KEY = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_a;
    logic [63:0] found_b;
    logic [63:0] found_c;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       hash;
    logic       walk_start;
    logic       rd;
    logic       adv;
    logic       scan_start;
    logic       scan_adv;
    logic       ins;
    logic       rem;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_hit;
    logic       res_words;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       key_zero;
    logic [1:0] action;
    logic       hash_last;
    logic       chain_end;
    logic       match;
    logic       scan_free;
    logic       scan_last;
  } sts_t;

  // One FNV-1a round: xor in a byte, multiply by the prime (shift plus small product)
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SH) + (x * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage

[rtl/core/fnvkht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fnvkht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/fnvkht_ctrl.sv]
// Controller state machine of the keyed hash table.
// Depends on fnvkht_pkg; drives the datapath through cmd_t, reads sts_t.
module fnvkht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fnvkht_pkg::cmd_t  cmd,
  input  fnvkht_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_DISP, S_WRD, S_WCHK, S_SCAN, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_last) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts.action != fnvkht_pkg::ACT_NONE && sts.key_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_BAD_KEY;
          state_next     = S_FIN;
        end else if (sts.action == fnvkht_pkg::ACT_INSERT) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.action == fnvkht_pkg::ACT_NONE) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_OK;
          state_next     = S_FIN;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WRD;
        end
      end
      S_WRD: begin
        if (sts.chain_end) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_OK;
          state_next     = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        if (sts.match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_OK;
          cmd.res_hit    = 1'b1;
          cmd.res_words  = (sts.action == fnvkht_pkg::ACT_LOOKUP);
          cmd.rem        = (sts.action == fnvkht_pkg::ACT_REMOVE);
          state_next     = S_FIN;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_WRD;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_free) begin
          cmd.ins        = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_OK;
          state_next     = S_FIN;
        end else if (sts.scan_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fnvkht_pkg::STAT_FULL;
          state_next     = S_FIN;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/fnvkht_dp.sv]
// Datapath of the keyed hash table: hash register, chain heads, occupancy,
// walk and scan pointers, node RAMs, result registers. Depends on fnvkht_pkg, fnvkht_ram.
module fnvkht_dp #(
  parameter int NODE_COUNT   = fnvkht_pkg::NODE_COUNT,
  parameter int BUCKET_COUNT = fnvkht_pkg::BUCKET_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  fnvkht_pkg::req_t  req,
  input  fnvkht_pkg::cmd_t  cmd,
  output fnvkht_pkg::sts_t  sts,
  output fnvkht_pkg::rsp_t  rsp
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int LW  = $clog2(NODE_COUNT + 1);
  localparam int BKW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [LW-1:0] NO_NODE = LW'(NODE_COUNT);

  fnvkht_pkg::req_t req_q;
  fnvkht_pkg::rsp_t res;
  logic [63:0]      hash;
  logic [1:0]       bidx;
  logic [LW-1:0]    heads [BUCKET_COUNT];
  logic [NODE_COUNT-1:0] occ;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    prev;
  logic [LW-1:0]    steps;
  logic [NW-1:0]    sidx;
  logic [BKW-1:0]   bkt;
  logic [NW-1:0]    cur_a;

  logic [31:0]      key_rd;
  logic [LW-1:0]    link_rd;
  logic [63:0]      wa_rd, wb_rd, wc_rd;
  logic             link_we;
  logic [NW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;

  assign bkt   = BKW'(hash & 64'(BUCKET_COUNT - 1));
  assign cur_a = cur[NW-1:0];

  assign sts.key_zero  = (req_q.key == 32'd0);
  assign sts.action    = req_q.action;
  assign sts.hash_last = (bidx == 2'd3);
  assign sts.chain_end = (cur >= NO_NODE) || (steps == NO_NODE);
  assign sts.match     = occ[cur_a] && (key_rd == req_q.key);
  assign sts.scan_free = !occ[sidx];
  assign sts.scan_last = (sidx == NW'(NODE_COUNT - 1));

  // Control state: chain heads and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        heads[i] <= NO_NODE;
      end
      occ <= '0;
    end else begin
      if (cmd.ins) begin
        heads[bkt] <= LW'(sidx);
        occ[sidx]  <= 1'b1;
      end
      if (cmd.rem) begin
        occ[cur_a] <= 1'b0;
        if (prev == NO_NODE) begin
          heads[bkt] <= link_rd;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      hash  <= fnvkht_pkg::FNV_BASIS;
      bidx  <= 2'd0;
    end
    if (cmd.hash) begin
      hash <= fnvkht_pkg::fnv_step(hash, req_q.key[{bidx, 3'b000} +: 8]);
      bidx <= bidx + 2'd1;
    end
    if (cmd.walk_start) begin
      cur   <= heads[bkt];
      prev  <= NO_NODE;
      steps <= '0;
    end
    if (cmd.adv) begin
      prev  <= cur;
      cur   <= link_rd;
      steps <= steps + LW'(1);
    end
    if (cmd.scan_start) begin
      sidx <= '0;
    end
    if (cmd.scan_adv) begin
      sidx <= sidx + NW'(1);
    end
    if (cmd.set_res) begin
      res.status  <= cmd.res_status;
      res.hit     <= cmd.res_hit;
      res.found_a <= cmd.res_words ? wa_rd : 64'd0;
      res.found_b <= cmd.res_words ? wb_rd : 64'd0;
      res.found_c <= cmd.res_words ? wc_rd : 64'd0;
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  // Link port: insert writes the new node, remove patches the predecessor
  assign link_we    = cmd.ins || (cmd.rem && (prev != NO_NODE));
  assign link_waddr = cmd.ins ? sidx : prev[NW-1:0];
  assign link_wdata = cmd.ins ? heads[bkt] : link_rd;

  fnvkht_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_key (
    .clk(clk), .we(cmd.ins), .waddr(sidx), .wdata(req_q.key),
    .re(cmd.rd), .raddr(cur_a), .rdata(key_rd)
  );

  fnvkht_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(cmd.rd), .raddr(cur_a), .rdata(link_rd)
  );

  fnvkht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_word_a (
    .clk(clk), .we(cmd.ins), .waddr(sidx), .wdata(req_q.word_a),
    .re(cmd.rd), .raddr(cur_a), .rdata(wa_rd)
  );

  fnvkht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_word_b (
    .clk(clk), .we(cmd.ins), .waddr(sidx), .wdata(req_q.word_b),
    .re(cmd.rd), .raddr(cur_a), .rdata(wb_rd)
  );

  fnvkht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_word_c (
    .clk(clk), .we(cmd.ins), .waddr(sidx), .wdata(req_q.word_c),
    .re(cmd.rd), .raddr(cur_a), .rdata(wc_rd)
  );

endmodule

[rtl/core/fnv_keyed_chained_hash_table.sv]
// Top level of the keyed FNV-1a chained hash table.
// Depends on fnvkht_pkg, fnvkht_ctrl, fnvkht_dp (and fnvkht_ram below it).
//
// Keyed table of NODE_COUNT entries, each a nonzero 32-bit key and three
// 64-bit words, hashed into BUCKET_COUNT chains by 64-bit FNV-1a over the
// key bytes, low byte first. Insert takes the lowest free node and pushes it
// on the head of its chain (no duplicate check); lookup returns the newest
// match; remove unlinks the first match. Key zero on a lookup, insert or
// remove answers "invalid" and changes nothing. One request beat gives
// exactly one response beat. Timing: the block works on one request at a
// time. It accepts the request, hashes the key (one key byte per cycle)
// and dispatches; then a lookup or remove walks the chain, reading each
// node from the node RAM and then comparing its key, and an insert scans
// for the lowest free node. The result is then handed to the output
// register. A lookup/remove that misses stops when the walk sees the chain
// end; a zero key or the unused action code goes from dispatch straight to
// the result. The output register lets the next request start while the
// previous response is still held by a stall.
// No clearing pass: chain heads and occupancy bits reset at once.
module fnv_keyed_chained_hash_table #(
  parameter int NODE_COUNT   = fnvkht_pkg::NODE_COUNT,
  parameter int BUCKET_COUNT = fnvkht_pkg::BUCKET_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  fnvkht_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output fnvkht_pkg::rsp_t rsp
);

  fnvkht_pkg::cmd_t cmd;
  fnvkht_pkg::sts_t sts;

  // Sequence each request: hash, then walk a chain or scan for a free node
  fnvkht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the table and the response beat
  fnvkht_dp #(
    .NODE_COUNT   (NODE_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

[rtl/core/fnvkht_checker.sv]
// Port-level checker for the keyed hash table, bound to the top level.
// Depends on fnvkht_pkg and fnv_keyed_chained_hash_table_macros.svh.
`include "fnv_keyed_chained_hash_table_macros.svh"

module fnvkht_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input fnvkht_pkg::rsp_t rsp
);

  logic words_zero;

  assign words_zero = (rsp.found_a == 64'd0) && (rsp.found_b == 64'd0) &&
                      (rsp.found_c == 64'd0);

  // A stalled response beat stays offered
  `FNVKHT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid, "response dropped")

  // Once a request beat is taken the block is busy on it
  `FNVKHT_ASSERT(a_busy_after_req, clk, rst, req_valid && !req_stall |=> req_stall, "not busy")

  // Found words are zero unless the beat reports a hit
  `FNVKHT_ASSERT(a_words_zero, clk, rst, rsp_valid && !rsp.hit |-> words_zero, "stray words")

  // No hit together with a failure status
  `FNVKHT_ASSERT(a_fail_no_hit, clk, rst, rsp_valid && rsp.status != fnvkht_pkg::STAT_OK |-> !rsp.hit, "hit on failure")

  // Reset empties the output register
  `FNVKHT_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !rsp_valid, "valid after reset")

endmodule

bind fnv_keyed_chained_hash_table fnvkht_checker u_fnvkht_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[bench/fnv_keyed_chained_hash_table_tb.sv]
// Self-checking bench for the keyed FNV-1a chained hash table: directed table, fill/drain,
// random traffic under varying idle patterns. Depends on fnvkht_pkg and the table RTL.
module fnv_keyed_chained_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODES      = 64;
  localparam int          BUCKETS    = 16;
  localparam logic [6:0]  END_OF_CHAIN = 7'd64;
  localparam logic [63:0] BASIS_64   = 64'hCBF29CE484222325;
  localparam logic [63:0] PRIME_64   = 64'h100000001B3;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          POOL_SIZE  = 24;

  typedef struct {
    fnvkht_pkg::req_t req;
    bit               typed;
    fnvkht_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  fnvkht_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fnvkht_pkg::rsp_t rsp;

  // Shadow copy of the table contents
  logic [6:0]  chain_head[BUCKETS];
  logic [31:0] node_key[NODES];
  logic [6:0]  node_link[NODES];
  logic [63:0] node_a[NODES];
  logic [63:0] node_b[NODES];
  logic [63:0] node_c[NODES];

  fnvkht_pkg::rsp_t pending_rsp[$];
  dir_row_t         dir_rows[$];
  logic [31:0]      key_pool[POOL_SIZE];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic long_hold = 1'b0;
  int   mismatches = 0;
  int   cycles = 0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   hits_seen = 0;
  int   full_seen = 0;

  fnv_keyed_chained_hash_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  // Bucket index: 64-bit FNV-1a over the key bytes, low byte first
  function automatic logic [3:0] bucket_of_key(logic [31:0] k);
    logic [63:0] h;
    h = BASIS_64;
    for (int i = 0; i < 4; i++) begin
      h = (h ^ {56'd0, k[8*i +: 8]}) * PRIME_64;
    end
    return h[3:0];
  endfunction

  // Apply one request to the shadow table and return the response it earns
  function automatic fnvkht_pkg::rsp_t apply_request(fnvkht_pkg::req_t r);
    fnvkht_pkg::rsp_t o;
    logic [3:0]       b;
    logic [6:0]       cur;
    logic [6:0]       prev;
    int               free_node;
    int               steps;
    o = '0;
    b = bucket_of_key(r.key);
    if (r.action != fnvkht_pkg::ACT_NONE && r.key == 32'd0) begin
      o.status = fnvkht_pkg::STAT_BAD_KEY;
    end else if (r.action == fnvkht_pkg::ACT_LOOKUP) begin
      cur = chain_head[b];
      steps = 0;
      while (cur < END_OF_CHAIN && steps < NODES) begin
        if (node_key[cur] == r.key) begin
          o.hit = 1'b1;
          o.found_a = node_a[cur];
          o.found_b = node_b[cur];
          o.found_c = node_c[cur];
          break;
        end
        cur = node_link[cur];
        steps++;
      end
    end else if (r.action == fnvkht_pkg::ACT_INSERT) begin
      free_node = NODES;
      for (int i = 0; i < NODES; i++) begin
        if (node_key[i] == 32'd0) begin
          free_node = i;
          break;
        end
      end
      if (free_node == NODES) begin
        o.status = fnvkht_pkg::STAT_FULL;
      end else begin
        node_key[free_node]  = r.key;
        node_a[free_node]    = r.word_a;
        node_b[free_node]    = r.word_b;
        node_c[free_node]    = r.word_c;
        node_link[free_node] = chain_head[b];
        chain_head[b]        = 7'(free_node);
      end
    end else if (r.action == fnvkht_pkg::ACT_REMOVE) begin
      prev = END_OF_CHAIN;
      cur = chain_head[b];
      steps = 0;
      while (cur < END_OF_CHAIN && steps < NODES) begin
        if (node_key[cur] == r.key) begin
          // unlink from predecessor or from the head, then free the node
          if (prev < END_OF_CHAIN) node_link[prev] = node_link[cur];
          else chain_head[b] = node_link[cur];
          node_key[cur]  = '0;
          node_link[cur] = '0;
          node_a[cur]    = '0;
          node_b[cur]    = '0;
          node_c[cur]    = '0;
          o.hit = 1'b1;
          break;
        end
        prev = cur;
        cur = node_link[cur];
        steps++;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH beat %0d %s: got %h want %h", beats_out, field, got, want);
  endtask

  // Offer one request beat, hold it until accepted, then record its expected response.
  // An idle gap lowers valid first; back-to-back beats keep valid high.
  task automatic send_beat(fnvkht_pkg::req_t item, bit typed, fnvkht_pkg::rsp_t want);
    fnvkht_pkg::rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    predicted = apply_request(item);
    pending_rsp.push_back(typed ? want : predicted);
    beats_in++;
  endtask

  function automatic fnvkht_pkg::req_t random_request(int insert_weight);
    fnvkht_pkg::req_t r;
    int               pick;
    r.word_a = {$urandom, $urandom};
    r.word_b = {$urandom, $urandom};
    r.word_c = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < insert_weight) r.action = fnvkht_pkg::ACT_INSERT;
    else if (pick < insert_weight + (100 - insert_weight) / 2) r.action = fnvkht_pkg::ACT_LOOKUP;
    else r.action = fnvkht_pkg::ACT_REMOVE;
    // mostly keys from a small pool so lookups and removes find something
    if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else r.key = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) r.key = '0;
    else if (pick < 8) r.action = fnvkht_pkg::ACT_NONE;
    return r;
  endfunction

  task automatic add_row(logic [1:0] act, logic [31:0] k, logic [63:0] w,
                         bit typed, logic [1:0] st, logic h, logic [63:0] fw);
    dir_row_t row;
    row.req = '{action: act, key: k, word_a: w, word_b: ~w, word_c: w ^ 64'h5A5A};
    row.typed = typed;
    row.want = '{status: st, hit: h, found_a: fw,
                 found_b: (h ? ~fw : 64'd0), found_c: (h ? fw ^ 64'h5A5A : 64'd0)};
    dir_rows.push_back(row);
  endtask

  task automatic random_phase(int count, int insert_weight);
    fnvkht_pkg::rsp_t none;
    none = '0;
    repeat (count) send_beat(random_request(insert_weight), 1'b0, none);
  endtask

  // Receiver: stall at random, or solidly while a long hold is on
  always @(posedge clk) begin
    if (long_hold) rsp_stall <= 1'b1;
    else rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare every accepted response beat with the oldest expectation
  always @(posedge clk) begin
    fnvkht_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", 64'(rsp.status), 64'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.hit !== want.hit)
          report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
        if (rsp.found_a !== want.found_a) report_mismatch("found_a", rsp.found_a, want.found_a);
        if (rsp.found_b !== want.found_b) report_mismatch("found_b", rsp.found_b, want.found_b);
        if (rsp.found_c !== want.found_c) report_mismatch("found_c", rsp.found_c, want.found_c);
        if (want.hit) hits_seen++;
        if (want.status == fnvkht_pkg::STAT_FULL) full_seen++;
      end
      beats_out++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending_rsp.size());
      $display("fnv_keyed_chained_hash_table_tb failed");
      $finish;
    end
  end

  // Hold the receiver off for a long stretch, counting its own cycles
  task automatic hold_receiver(int stretch);
    long_hold <= 1'b1;
    repeat (stretch) @(posedge clk);
    long_hold <= 1'b0;
  endtask

  initial begin
    int drain_wait;
    for (int i = 0; i < BUCKETS; i++) chain_head[i] = END_OF_CHAIN;
    for (int i = 0; i < NODES; i++) begin
      node_key[i] = '0;
      node_link[i] = '0;
      node_a[i] = '0;
      node_b[i] = '0;
      node_c[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom | 32'd1;

    // Directed: bad key on lookup, insert and remove, ignored action code, extremes, duplicates
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'd0, '1, 1, fnvkht_pkg::STAT_BAD_KEY, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_INSERT, 32'd0, '1, 1, fnvkht_pkg::STAT_BAD_KEY, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, 32'd0, '1, 1, fnvkht_pkg::STAT_BAD_KEY, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_NONE,   32'd0, '1, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, '1, '0, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, '1, '0, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_INSERT, '1, '1, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, '1, '0, 1, fnvkht_pkg::STAT_OK, 1'b1, '1);
    add_row(fnvkht_pkg::ACT_INSERT, 32'd1, '0, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_INSERT, 32'd1, 64'hA5A5_0F0F_1234_8001, 1,
            fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_NONE,   32'd1, '1, 1, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001, 1,
            fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_INSERT, 32'h0000_0080, 64'h0123_4567_89AB_CDEF, 1,
            fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'h8000_0000, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_LOOKUP, 32'h0000_0080, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, '1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);
    add_row(fnvkht_pkg::ACT_REMOVE, 32'd1, '0, 0, fnvkht_pkg::STAT_OK, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase one: sender idles a third of the time, receiver nearly half
    send_idle_pct = 33;
    recv_idle_pct = 46;
    foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    random_phase(120, 40);

    // Long receiver hold while requests keep coming: fills the output path
    fork
      hold_receiver(400);
    join_none
    random_phase(20, 40);

    // Pause until everything in flight has come back
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(posedge clk);

    // Phase two: roles swapped; fill the table past capacity, then drain it
    send_idle_pct = 46;
    recv_idle_pct = 33;
    random_phase(80, 100);
    random_phase(60, 10);
    random_phase(80, 40);

    // Phase three: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(90, 45);

    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    // let any trailing response show up before the verdict
    drain_wait = 0;
    while (drain_wait < 80) begin
      @(posedge clk);
      drain_wait++;
    end

    $display("covered %0d requests, %0d responses: %0d hits, %0d table-full answers",
             beats_in, beats_out, hits_seen, full_seen);
    $display("idle patterns: sender-heavy, receiver-heavy, none; plus one long receiver hold");
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("fnv_keyed_chained_hash_table_tb passed");
    end else begin
      $display("fnv_keyed_chained_hash_table_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/fnvkht_pkg.sv
rtl/core/fnvkht_ram.sv
rtl/core/fnvkht_ctrl.sv
rtl/core/fnvkht_dp.sv
rtl/core/fnv_keyed_chained_hash_table.sv
rtl/core/fnvkht_checker.sv
bench/fnv_keyed_chained_hash_table_tb.sv
